/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define LFB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define LFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lfb_pkg.sv */
`timescale 1ns / 1ps

package lfb_pkg;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_FLASH = 2'd2;
    localparam logic [1:0] MODE_BEEP  = 2'd3;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_ON  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_OFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT    = 3'd4;

    localparam int CFG_DATA_W   = 48;
    localparam int FLASH_W      = 16;
    localparam int FLASH_TOT_W  = FLASH_W + 1;
    localparam int SLOT_REG_W   = 48;
    localparam int SLOT_MAX     = 8;
    localparam int SLOT_BYTE_W  = 8;
    localparam int SLOT_OUT_W   = 3;

    localparam int SLOT_COUNT_DEF   = 6;
    localparam int SLOT_UNIT_MS_DEF = 50;

    localparam logic REPEAT_RESET = 1'b1;

    typedef struct packed {
        logic                  drive;
        logic                  finished;
        logic [SLOT_OUT_W-1:0] current_slot;
    } res_t;

endpackage

/* rtl/lfb_cfg.sv */
`timescale 1ns / 1ps

module lfb_cfg #(
    parameter int SLOT_COUNT   = lfb_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_UNIT_MS = lfb_pkg::SLOT_UNIT_MS_DEF,
    parameter int PHASE_W      = 17,
    parameter int NSLOT_W      = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr,
    input  logic [lfb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lfb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [1:0]                          mode,
    output logic [lfb_pkg::FLASH_W-1:0]         flash_on,
    output logic                                repeat_en,
    output logic [PHASE_W-1:0]                  total,
    output logic [PHASE_W-1:0]                  bound [SLOT_COUNT],
    output logic [NSLOT_W-1:0]                  nslot
);

    logic [1:0]                        mode_reg;
    logic [lfb_pkg::FLASH_W-1:0]       on_reg;
    logic [lfb_pkg::FLASH_W-1:0]       off_reg;
    logic [lfb_pkg::SLOT_REG_W-1:0]    slots_reg;
    logic                              repeat_reg;

    logic [PHASE_W-1:0] total_reg;
    logic [PHASE_W-1:0] total_next;
    logic [PHASE_W-1:0] bound_reg [SLOT_COUNT];
    logic [PHASE_W-1:0] bound_next [SLOT_COUNT];
    logic [NSLOT_W-1:0] nslot_reg;
    logic [NSLOT_W-1:0] nslot_next;

    logic [lfb_pkg::SLOT_MAX*lfb_pkg::SLOT_BYTE_W-1:0] slots_pad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= lfb_pkg::MODE_OFF;
            on_reg     <= '0;
            off_reg    <= '0;
            slots_reg  <= '0;
            repeat_reg <= lfb_pkg::REPEAT_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                lfb_pkg::CFG_MODE:      mode_reg   <= cfg_data[1:0];
                lfb_pkg::CFG_FLASH_ON:  on_reg     <= cfg_data[lfb_pkg::FLASH_W-1:0];
                lfb_pkg::CFG_FLASH_OFF: off_reg    <= cfg_data[lfb_pkg::FLASH_W-1:0];
                lfb_pkg::CFG_SLOTS:     slots_reg  <= cfg_data[lfb_pkg::SLOT_REG_W-1:0];
                lfb_pkg::CFG_REPEAT:    repeat_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    assign slots_pad = {{(lfb_pkg::SLOT_MAX*lfb_pkg::SLOT_BYTE_W-lfb_pkg::SLOT_REG_W){1'b0}},
                        slots_reg};

    // Prefix sums of the active slots; the first zero slot stops the list.
    always_comb
    begin
        logic               act;
        logic [PHASE_W-1:0] acc;
        logic [PHASE_W-1:0] len;
        act        = 1'b1;
        acc        = '0;
        nslot_next = '0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            len = PHASE_W'(slots_pad[k*lfb_pkg::SLOT_BYTE_W +: lfb_pkg::SLOT_BYTE_W])
                * PHASE_W'(SLOT_UNIT_MS);
            if (act && len != '0)
            begin
                acc        = acc + len;
                nslot_next = nslot_next + NSLOT_W'(1);
            end
            else
            begin
                act = 1'b0;
            end
            bound_next[k] = acc;
        end
        case (mode_reg)
            lfb_pkg::MODE_FLASH:
                total_next = PHASE_W'(lfb_pkg::FLASH_TOT_W'(on_reg)
                                    + lfb_pkg::FLASH_TOT_W'(off_reg));
            lfb_pkg::MODE_BEEP:
                total_next = acc;
            default:
                total_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            nslot_reg <= '0;
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                bound_reg[k] <= '0;
            end
        end
        else
        begin
            total_reg <= total_next;
            nslot_reg <= nslot_next;
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                bound_reg[k] <= bound_next[k];
            end
        end
    end

    assign mode      = mode_reg;
    assign flash_on  = on_reg;
    assign repeat_en = repeat_reg;
    assign total     = total_reg;
    assign bound     = bound_reg;
    assign nslot     = nslot_reg;

endmodule

/* rtl/lfb_mod.sv */
`timescale 1ns / 1ps

// Bit-serial restoring remainder, one dividend bit per cycle.
module lfb_mod #(
    parameter int W = 17
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     dvd_reg;
    logic [W-1:0]     rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [W:0]       trial;

    assign trial = {rem_reg, dvd_reg[W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            if (trial >= {1'b0, divisor})
            begin
                rem_reg <= W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_reg <= W'(trial);
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/lfb_core.sv */
`timescale 1ns / 1ps

module lfb_core #(
    parameter int SLOT_COUNT = lfb_pkg::SLOT_COUNT_DEF,
    parameter int PHASE_W    = 17,
    parameter int NSLOT_W    = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          advance,
    input  logic                          restart,
    input  logic                          q_full,
    output logic                          push,
    output lfb_pkg::res_t                 res,
    input  logic [1:0]                    mode,
    input  logic [lfb_pkg::FLASH_W-1:0]   flash_on,
    input  logic                          repeat_en,
    input  logic [PHASE_W-1:0]            total,
    input  logic [PHASE_W-1:0]            bound [SLOT_COUNT],
    input  logic [NSLOT_W-1:0]            nslot
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SETTLE = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic               done_reg;
    logic               done_next;

    logic               mod_start;
    logic               mod_done;
    logic [PHASE_W-1:0] mod_rem;
    logic               accept;

    logic [PHASE_W-1:0] p0;
    logic [PHASE_W-1:0] p1;
    logic [PHASE_W-1:0] pinc;
    logic               d0;
    logic [NSLOT_W-1:0] which;

    lfb_mod #(
        .W (PHASE_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (phase_reg),
        .divisor   (total),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign in_ready  = (state_reg == ST_IDLE) && !q_full;
    assign accept    = in_valid && in_ready;
    assign push      = accept;
    assign mod_start = (state_reg == ST_SETTLE) && !cfg_wr;

    // A configuration write may leave the phase beyond the new period, so the
    // phase is reduced once before the next item is taken.
    always_comb
    begin
        state_next = state_reg;
        if (cfg_wr)
        begin
            state_next = ST_SETTLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:   state_next = ST_IDLE;
                ST_SETTLE: state_next = ST_RUN;
                ST_RUN:    state_next = mod_done ? ST_IDLE : ST_RUN;
                default:   state_next = ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        p0   = restart ? '0 : phase_reg;
        d0   = restart ? 1'b0 : done_reg;
        pinc = p0 + PHASE_W'(1);
        if (total != '0 && advance && !((mode == lfb_pkg::MODE_BEEP) && d0))
        begin
            p1 = (pinc == total) ? '0 : pinc;
        end
        else
        begin
            p1 = p0;
        end

        // Bounds rise strictly over the active slots, so the slot index is the
        // number of bounds already passed.
        which = '0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            if (NSLOT_W'(k) < nslot && p1 >= bound[k])
            begin
                which = which + NSLOT_W'(1);
            end
        end

        done_next        = d0;
        res.drive        = 1'b0;
        res.finished     = 1'b0;
        res.current_slot = '0;
        case (mode)
            lfb_pkg::MODE_ON:
                res.drive = 1'b1;
            lfb_pkg::MODE_FLASH:
                res.drive = (total != '0) && (p1 <= PHASE_W'(flash_on));
            lfb_pkg::MODE_BEEP:
            begin
                if (total != '0)
                begin
                    res.current_slot = lfb_pkg::SLOT_OUT_W'(which);
                    if (!d0)
                    begin
                        res.drive = !which[0];
                        if (which == nslot - NSLOT_W'(1) && which[0] && !repeat_en)
                        begin
                            done_next = 1'b1;
                        end
                    end
                end
                if (done_next)
                begin
                    res.drive    = 1'b0;
                    res.finished = 1'b1;
                end
            end
            default:
                res.drive = 1'b0;
        endcase

        phase_next = p1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                done_reg  <= done_next;
            end
            else if (state_reg == ST_RUN && mod_done && !cfg_wr)
            begin
                phase_reg <= mod_rem;
            end
        end
    end

endmodule

/* rtl/lfb_outq.sv */
`timescale 1ns / 1ps

// Two-entry result queue so a new beat is taken while a result waits.
module lfb_outq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lfb_pkg::res_t push_data,
    output logic          full,
    output logic          out_valid,
    input  logic          out_ready,
    output lfb_pkg::res_t out_data
);

    lfb_pkg::res_t ent_reg [2];
    logic          wptr_reg;
    logic          rptr_reg;
    logic [1:0]    cnt_reg;
    logic          pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign pop       = out_valid && out_ready;
    assign out_data  = ent_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/led_flash_and_beep_pattern_top.sv */
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_ready    advance, restart
// result    out_valid / out_ready  drive, finished, current_slot
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One input beat is taken per cycle while in_ready is high; its result appears
// in the queue the next cycle, and the two-entry queue keeps the input open
// while a result waits. After any config beat, in_ready drops while the core
// settles and the bit-serial remainder unit folds the phase into the new
// period. cfg_ready is always high.
// Reset clears the phase, the finished mark and the queue, and loads the
// register reset values.
module led_flash_and_beep_pattern_top #(
    parameter int SLOT_COUNT   = lfb_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_UNIT_MS = lfb_pkg::SLOT_UNIT_MS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             advance,
    input  logic                             restart,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             drive,
    output logic                             finished,
    output logic [lfb_pkg::SLOT_OUT_W-1:0]   current_slot,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lfb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int BEEP_MAX = 255 * SLOT_UNIT_MS * SLOT_COUNT;
    localparam int BEEP_W   = $clog2(BEEP_MAX + 1);
    localparam int PHASE_W  = (BEEP_W > lfb_pkg::FLASH_TOT_W) ? BEEP_W : lfb_pkg::FLASH_TOT_W;
    localparam int NSLOT_W  = $clog2(SLOT_COUNT + 1);

    logic                        cfg_wr;
    logic [1:0]                  mode;
    logic [lfb_pkg::FLASH_W-1:0] flash_on;
    logic                        repeat_en;
    logic [PHASE_W-1:0]          total;
    logic [PHASE_W-1:0]          bound [SLOT_COUNT];
    logic [NSLOT_W-1:0]          nslot;
    logic                        q_full;
    logic                        push;
    lfb_pkg::res_t               res;
    lfb_pkg::res_t               out_data;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    lfb_cfg #(
        .SLOT_COUNT   (SLOT_COUNT),
        .SLOT_UNIT_MS (SLOT_UNIT_MS),
        .PHASE_W      (PHASE_W),
        .NSLOT_W      (NSLOT_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mode      (mode),
        .flash_on  (flash_on),
        .repeat_en (repeat_en),
        .total     (total),
        .bound     (bound),
        .nslot     (nslot)
    );

    lfb_core #(
        .SLOT_COUNT (SLOT_COUNT),
        .PHASE_W    (PHASE_W),
        .NSLOT_W    (NSLOT_W)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .advance   (advance),
        .restart   (restart),
        .q_full    (q_full),
        .push      (push),
        .res       (res),
        .mode      (mode),
        .flash_on  (flash_on),
        .repeat_en (repeat_en),
        .total     (total),
        .bound     (bound),
        .nslot     (nslot)
    );

    lfb_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .full      (q_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign drive        = out_data.drive;
    assign finished     = out_data.finished;
    assign current_slot = out_data.current_slot;

endmodule

/* rtl/lfb_checker.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lfb_checker #(
    parameter int SLOT_COUNT = lfb_pkg::SLOT_COUNT_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           drive,
    input logic                           finished,
    input logic [lfb_pkg::SLOT_OUT_W-1:0] current_slot
);

    // A finished pattern never drives the output.
    `LFB_ASSERT_ALWAYS(a_fin_off, !(out_valid && finished && drive), "finished result drives")

    // The slot number stays below the SLOT_COUNT parameter.
    `LFB_ASSERT_ALWAYS(a_slot_rng, !out_valid || ({1'b0, current_slot} < (lfb_pkg::SLOT_OUT_W+1)'(SLOT_COUNT)), "slot out of range")

    // The phase is reduced after a config beat, so input is closed in the cycle after it.
    `LFB_ASSERT_NEXT(a_cfg_stall, cfg_valid && cfg_ready, !in_ready, "input open after config beat")

    // A result beat that is not taken holds.
    `LFB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive) && $stable(finished) && $stable(current_slot), "stalled result changed")

endmodule

bind led_flash_and_beep_pattern_top lfb_checker #(
    .SLOT_COUNT (SLOT_COUNT)
) u_lfb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive        (drive),
    .finished     (finished),
    .current_slot (current_slot)
);

/* tb/sv/tb_led_flash_and_beep_pattern_top.sv */
`timescale 1ns / 1ps

module tb_led_flash_and_beep_pattern_top;

    localparam int QUIET_LIMIT = 2000;
    localparam int SLOT_NUM    = lfb_pkg::SLOT_COUNT_DEF;
    localparam int SLOT_UNIT   = lfb_pkg::SLOT_UNIT_MS_DEF;
    localparam int ITEM_GOAL   = 950;
    localparam int CALM_FROM   = 850;

    class lamp_scoreboard;
        // Shadow copy of the configuration registers.
        logic [1:0]                     lamp_mode    = lfb_pkg::MODE_OFF;
        logic [lfb_pkg::FLASH_W-1:0]    on_ms        = '0;
        logic [lfb_pkg::FLASH_W-1:0]    off_ms       = '0;
        logic [lfb_pkg::SLOT_REG_W-1:0] slot_bytes   = '0;
        logic                           loop_pattern = lfb_pkg::REPEAT_RESET;
        // Shadow copy of the channel state.
        int unsigned   elapsed = 0;
        bit            ended   = 1'b0;
        lfb_pkg::res_t expected_lamp[$];
        int            errors  = 0;
        int            seen    = 0;

        function int pending();
            return expected_lamp.size();
        endfunction

        function void set_reg(logic [lfb_pkg::CFG_IDX_W-1:0] idx,
                              logic [lfb_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lfb_pkg::CFG_MODE:      lamp_mode    = data[1:0];
                lfb_pkg::CFG_FLASH_ON:  on_ms        = data[lfb_pkg::FLASH_W-1:0];
                lfb_pkg::CFG_FLASH_OFF: off_ms       = data[lfb_pkg::FLASH_W-1:0];
                lfb_pkg::CFG_SLOTS:     slot_bytes   = data[lfb_pkg::SLOT_REG_W-1:0];
                lfb_pkg::CFG_REPEAT:    loop_pattern = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned slot_ms(int k);
            if (k >= lfb_pkg::SLOT_REG_W / lfb_pkg::SLOT_BYTE_W)
                return 0;
            return int'(slot_bytes[lfb_pkg::SLOT_BYTE_W*k +: lfb_pkg::SLOT_BYTE_W])
                   * SLOT_UNIT;
        endfunction

        // Advances the shadow state by one input beat and queues the lamp state.
        function void take_tick(bit adv, bit rst);
            int unsigned   period;
            int unsigned   acc;
            int            nact;
            int            which;
            bit            found;
            lfb_pkg::res_t want;
            period = 0;
            nact   = 0;
            want   = '0;
            if (rst) begin
                elapsed = 0;
                ended   = 1'b0;
            end
            if (lamp_mode == lfb_pkg::MODE_FLASH) begin
                period = int'(on_ms) + int'(off_ms);
            end else if (lamp_mode == lfb_pkg::MODE_BEEP) begin
                while (nact < SLOT_NUM && slot_ms(nact) != 0) begin
                    period += slot_ms(nact);
                    nact++;
                end
            end
            if (period != 0) begin
                elapsed = elapsed % period;
                if (adv && !(lamp_mode == lfb_pkg::MODE_BEEP && ended)) begin
                    elapsed++;
                    if (elapsed >= period)
                        elapsed = 0;
                end
            end
            case (lamp_mode)
                lfb_pkg::MODE_ON:    want.drive = 1'b1;
                lfb_pkg::MODE_FLASH: want.drive = (period != 0 && elapsed <= on_ms);
                lfb_pkg::MODE_BEEP:
                begin
                    if (period != 0) begin
                        acc   = 0;
                        which = nact - 1;
                        found = 1'b0;
                        for (int k = 0; k < nact; k++) begin
                            acc += slot_ms(k);
                            if (!found && elapsed < acc) begin
                                which = k;
                                found = 1'b1;
                            end
                        end
                        want.current_slot = lfb_pkg::SLOT_OUT_W'(which);
                        if (!ended) begin
                            want.drive = !which[0];
                            // An odd final slot ends a pattern that does not loop.
                            if (which == nact - 1 && which[0] && !loop_pattern)
                                ended = 1'b1;
                        end
                    end
                    if (ended) begin
                        want.drive    = 1'b0;
                        want.finished = 1'b1;
                    end
                end
                default: ;
            endcase
            expected_lamp.push_back(want);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch at result %0d, %s: got %0d, expected %0d", seen, what, got, want);
            errors++;
        endtask

        task check_lamp(lfb_pkg::res_t got);
            lfb_pkg::res_t want;
            seen++;
            if (expected_lamp.size() == 0) begin
                report_mismatch("result beat with nothing pending", 1, 0);
                return;
            end
            want = expected_lamp.pop_front();
            if (got.drive !== want.drive)
                report_mismatch("drive", got.drive, want.drive);
            if (got.finished !== want.finished)
                report_mismatch("finished", got.finished, want.finished);
            if (got.current_slot !== want.current_slot)
                report_mismatch("current_slot", got.current_slot, want.current_slot);
        endtask
    endclass

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic                           advance   = 1'b0;
    logic                           restart   = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic                           drive;
    logic                           finished;
    logic [lfb_pkg::SLOT_OUT_W-1:0] current_slot;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [lfb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lfb_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    lfb_pkg::res_t  lamp_seen;
    lamp_scoreboard sb;
    bit             calm       = 1'b0;
    int             stall_left = 0;
    int             quiet      = 0;
    int             ticks_sent = 0;

    assign lamp_seen = {drive, finished, current_slot};

    led_flash_and_beep_pattern_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .advance      (advance),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive        (drive),
        .finished     (finished),
        .current_slot (current_slot),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side back-pressure in short random bursts.
    always @(posedge clk)
    begin
        if (calm || !rst_n) begin
            out_ready <= rst_n;
        end else if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 2);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Beat monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.take_tick(advance, restart);
            if (out_valid && out_ready)
                sb.check_lamp(lamp_seen);
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic [lfb_pkg::CFG_DATA_W-1:0] rand48();
        return lfb_pkg::CFG_DATA_W'({$urandom, $urandom});
    endfunction

    task automatic tick(input bit adv, input bit rst);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        advance  <= adv;
        restart  <= rst;
        do @(posedge clk); while (!in_ready);
        ticks_sent++;
    endtask

    // Holds off input and waits until every queued result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [lfb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lfb_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [1:0] m, input logic [lfb_pkg::FLASH_W-1:0] on_t,
                             input logic [lfb_pkg::FLASH_W-1:0] off_t,
                             input logic [lfb_pkg::SLOT_REG_W-1:0] slots, input bit rp);
        logic [lfb_pkg::CFG_DATA_W-1:0] junk;
        settle();
        // Bits above each register's width must be dropped.
        junk = ($urandom_range(0, 1) == 0) ? '0 : rand48();
        write_reg(lfb_pkg::CFG_MODE, {junk[lfb_pkg::CFG_DATA_W-3:0], m});
        write_reg(lfb_pkg::CFG_FLASH_ON,
                  {junk[lfb_pkg::CFG_DATA_W-lfb_pkg::FLASH_W-1:0], on_t});
        write_reg(lfb_pkg::CFG_FLASH_OFF,
                  {junk[lfb_pkg::CFG_DATA_W-lfb_pkg::FLASH_W-1:0], off_t});
        write_reg(lfb_pkg::CFG_SLOTS, slots);
        write_reg(lfb_pkg::CFG_REPEAT, {junk[lfb_pkg::CFG_DATA_W-2:0], rp});
        if ($urandom_range(0, 2) == 0)
            write_reg(lfb_pkg::CFG_REPEAT + lfb_pkg::CFG_IDX_W'($urandom_range(1, 3)),
                      rand48());
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [1:0]                     m;
        logic [lfb_pkg::FLASH_W-1:0]    on_t;
        logic [lfb_pkg::FLASH_W-1:0]    off_t;
        logic [lfb_pkg::SLOT_REG_W-1:0] sl;
        bit                             rp;
        int                             r;
        int                             n;
        int                             nact;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting from the reset settings.
        tick(0, 0);
        tick(1, 0);
        tick(1, 1);
        configure(lfb_pkg::MODE_ON, 0, 0, 0, 1);
        tick(1, 0);
        tick(0, 1);
        configure(lfb_pkg::MODE_FLASH, 2, 3, 0, 1);
        repeat (5) tick(1, 0);
        tick(1, 1);
        tick(1, 0);
        // Zero period gives a dark lamp, zero off time a steady one.
        configure(lfb_pkg::MODE_FLASH, 0, 0, 0, 1);
        tick(1, 0);
        configure(lfb_pkg::MODE_FLASH, 3, 0, 0, 0);
        tick(1, 0);
        tick(1, 0);
        configure(lfb_pkg::MODE_FLASH, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1);
        tick(1, 0);
        // A zero first slot leaves no pattern at all.
        configure(lfb_pkg::MODE_BEEP, 0, 0, 48'h0A0B_0C0D_0E00, 1);
        tick(1, 0);
        configure(lfb_pkg::MODE_BEEP, 16'hFFFF, 0, 48'hFFFF_FFFF_FFFF, 0);
        tick(1, 1);
        tick(1, 0);
        // Slots after the first zero one are ignored.
        configure(lfb_pkg::MODE_BEEP, 0, 16'hFFFF, 48'hFF07_0300_0101, 0);
        tick(1, 0);

        // Random part: short patterns so that loops and endings are reached often.
        while (ticks_sent < ITEM_GOAL) begin
            r = $urandom_range(0, 9);
            m = (r == 0) ? lfb_pkg::MODE_OFF : (r == 1) ? lfb_pkg::MODE_ON :
                (r < 5) ? lfb_pkg::MODE_FLASH : lfb_pkg::MODE_BEEP;
            on_t  = $urandom_range(0, 12);
            off_t = $urandom_range(0, 12);
            if ($urandom_range(0, 7) == 0)
                on_t = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom);
            if ($urandom_range(0, 7) == 0)
                off_t = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom);
            nact = $urandom_range(1, 4);
            sl   = rand48();
            for (int k = 0; k < SLOT_NUM; k++) begin
                if (k < nact)
                    sl[8*k +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                                : 8'($urandom_range(1, 2));
                else if (k == nact)
                    sl[8*k +: 8] = 8'h00;
            end
            rp = $urandom_range(0, 1);
            configure(m, on_t, off_t, sl, rp);
            n = $urandom_range(40, 200);
            if ($urandom_range(0, 1) == 0)
                tick(1, 1);
            for (int i = 0; i < n && ticks_sent < ITEM_GOAL; i++) begin
                calm = (ticks_sent >= CALM_FROM);
                tick($urandom_range(0, 9) != 0, $urandom_range(0, 49) == 0);
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
